// ----- rtl/nlms_pkg.sv -----
// Shared types, constants and saturation helpers of the NLMS adaptive filter.
`timescale 1ns / 1ps
package nlms_pkg;

  localparam int TAPS_DEFAULT = 32;

  // Divider sizing: divisor is regularization plus a norm of up to 256 taps.
  localparam int DIV_W = 40;
  localparam int NUM_W = 62;
  localparam int Q_W   = 41;
  localparam logic [Q_W-1:0] MAG_MAX = Q_W'(1) << (Q_W - 1);

  localparam logic [15:0] STEP_RESET = 16'd3277;
  localparam logic [31:0] REG_RESET  = 32'd1024;

  // Configuration register indexes.
  localparam logic [1:0] CFG_STEP_SIZE  = 2'd0;
  localparam logic [1:0] CFG_REGULARIZE = 2'd1;
  localparam logic [1:0] CFG_ERROR_MODE = 2'd2;

  // Accumulator operations.
  localparam logic [1:0] ACC_HOLD = 2'd0;
  localparam logic [1:0] ACC_INIT = 2'd1;
  localparam logic [1:0] ACC_ADD  = 2'd2;

  typedef struct packed {
    logic signed [15:0] sample;
    logic signed [15:0] reference;
  } item_t;

  typedef struct packed {
    logic signed [15:0] estimate;
    logic signed [15:0] error_value;
  } result_t;

  typedef struct packed {
    logic       mul_en;
    logic [1:0] acc_op;
  } mac_ctl_t;

  function automatic logic signed [15:0] sat16(input logic signed [63:0] v);
    if (v > 64'sd32767) begin
      return 16'sh7fff;
    end else if (v < -64'sd32768) begin
      return 16'sh8000;
    end
    return v[15:0];
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) begin
      return 32'sh7fffffff;
    end else if (v < -64'sd2147483648) begin
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

endpackage

// ----- rtl/nlms_mac.sv -----
// Shared multiplier with registered product and a 64-bit accumulator.
`timescale 1ns / 1ps
module nlms_mac (
  input  logic                clk,
  input  nlms_pkg::mac_ctl_t  ctl,
  input  logic signed [32:0]  a,
  input  logic signed [16:0]  b,
  input  logic signed [63:0]  acc_init,
  output logic signed [49:0]  prod,
  output logic signed [63:0]  acc
);

  always_ff @(posedge clk) begin
    if (ctl.mul_en) begin
      prod <= a * b;
    end
    case (ctl.acc_op)
      nlms_pkg::ACC_INIT: acc <= acc_init;
      nlms_pkg::ACC_ADD:  acc <= acc + {{14{prod[49]}}, prod};
      default:            acc <= acc;
    endcase
  end

endmodule

// ----- rtl/nlms_div.sv -----
// Bit-serial restoring divider with rounding-free quotient clamp for weight deltas.
`timescale 1ns / 1ps
module nlms_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [nlms_pkg::NUM_W-1:0]    dividend,
  input  logic [nlms_pkg::DIV_W-1:0]    divisor,
  output logic                          done,
  output logic [nlms_pkg::Q_W-1:0]      mag
);

  logic                         run;
  logic                         ovf;
  logic [5:0]                   cnt;
  logic [nlms_pkg::DIV_W-1:0]   rem;
  logic [nlms_pkg::Q_W-1:0]     quo;
  logic [nlms_pkg::DIV_W-1:0]   hi;
  logic [nlms_pkg::DIV_W:0]     trial;
  logic                         ge;

  // A quotient of 2^Q_W or more is clamped anyway, so its upper part is only tested.
  assign hi    = nlms_pkg::DIV_W'(dividend[nlms_pkg::NUM_W-1:nlms_pkg::Q_W]);
  assign trial = {rem, quo[nlms_pkg::Q_W-1]};
  assign ge    = trial >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      if (hi >= divisor) begin
        run  <= 1'b0;
        done <= 1'b1;
      end else begin
        run  <= 1'b1;
        done <= 1'b0;
        cnt  <= 6'(nlms_pkg::Q_W);
      end
    end else if (run) begin
      cnt <= cnt - 6'd1;
      if (cnt == 6'd1) begin
        run  <= 1'b0;
        done <= 1'b1;
      end
    end else begin
      done <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      ovf <= hi >= divisor;
      rem <= hi;
      quo <= dividend[nlms_pkg::Q_W-1:0];
    end else if (run) begin
      rem <= ge ? nlms_pkg::DIV_W'(trial - {1'b0, divisor}) : trial[nlms_pkg::DIV_W-1:0];
      quo <= {quo[nlms_pkg::Q_W-2:0], ge};
    end
  end

  assign mag = (ovf || quo > nlms_pkg::MAG_MAX) ? nlms_pkg::MAG_MAX : quo;

endmodule

// ----- rtl/nlms_adaptive_fir.sv -----
// Top level of the normalized LMS adaptive FIR filter with its sequencer and memories.
`timescale 1ns / 1ps
// Usage:
// An input transfer on item (valid/ready) brings a Q1.15 sample and a reference.
// Each item yields exactly one result transfer on result (valid/ready) with the
// saturated estimate and the error used to adapt the weights.
// Configuration writes go over cfg (valid/ready, index and data); cfg_ready is
// always high, and writes are meant to happen only while the filter is idle.
// The bulk of each item is the weight update: every tap runs one bit-serial
// division of 41 quotient bits, cut short when the quotient is known to clamp,
// besides a pass over the taps each for the dot product and the squared norm,
// all through a single shared multiplier. If the divisor is zero the update
// is skipped and only the filtering and the norm are done for the item.
// item_ready is high only in the idle state; the filter works on one item at a time.
// After reset the delay line and weights are cleared in a pass over all taps,
// during which no item is taken. A finished result waits in an output register;
// if the receiver stalls, the next item is still accepted and processed, and the
// filter holds before loading its own result until the register is free.
module nlms_adaptive_fir #(
  parameter int TAPS = nlms_pkg::TAPS_DEFAULT
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_ready,
  input  nlms_pkg::item_t   item,
  output logic              result_valid,
  input  logic              result_ready,
  output nlms_pkg::result_t result,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [1:0]        cfg_index,
  input  logic [31:0]       cfg_data
);

  localparam int AW = (TAPS > 1) ? $clog2(TAPS) : 1;
  localparam logic [AW-1:0] LAST = AW'(TAPS - 1);

  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_STORE = 4'd2;
  localparam logic [3:0] S_FILT  = 4'd3;
  localparam logic [3:0] S_ROUND = 4'd4;
  localparam logic [3:0] S_ERR   = 4'd5;
  localparam logic [3:0] S_NORM  = 4'd6;
  localparam logic [3:0] S_NCHK  = 4'd7;
  localparam logic [3:0] S_COEF  = 4'd8;
  localparam logic [3:0] S_ADAPT = 4'd9;
  localparam logic [3:0] S_DIV   = 4'd10;
  localparam logic [3:0] S_WB    = 4'd11;
  localparam logic [3:0] S_DONE  = 4'd12;

  // Configuration registers.
  logic [15:0] step_size;
  logic [31:0] regularization;
  logic        error_input_mode;

  // Sequencer state.
  logic [3:0]    state;
  logic [1:0]    ph;
  logic [AW-1:0] k;
  logic [AW-1:0] slot;
  logic [AW-1:0] wpos;
  logic          mode;

  // Per-item working registers.
  logic signed [15:0]          sample_r;
  logic signed [15:0]          ref_r;
  logic signed [15:0]          err;
  logic signed [35:0]          est_full;
  logic [nlms_pkg::DIV_W-1:0]  dsum;
  logic [31:0]                 coef;
  logic                        neg;

  // Memories and their registered read data.
  logic signed [15:0] x_mem [TAPS];
  logic signed [31:0] w_mem [TAPS];
  logic signed [15:0] x_q;
  logic signed [31:0] w_q;
  logic               x_we;
  logic [AW-1:0]      x_waddr;
  logic signed [15:0] x_wdata;
  logic [AW-1:0]      x_addr;
  logic               w_we;
  logic signed [31:0] w_wdata;

  // Shared arithmetic.
  nlms_pkg::mac_ctl_t          mac_ctl;
  logic signed [32:0]          mul_a;
  logic signed [16:0]          mul_b;
  logic signed [63:0]          acc_init;
  logic signed [49:0]          prod;
  logic signed [63:0]          acc;
  logic                        div_start;
  logic                        div_done;
  logic [nlms_pkg::Q_W-1:0]    div_mag;
  logic [nlms_pkg::NUM_W-1:0]  dividend;

  logic [AW-1:0]      slot_start;
  logic [AW-1:0]      slot_dec;
  logic [AW-1:0]      wpos_inc;
  logic [15:0]        abs_x;
  logic [15:0]        abs_err;
  logic signed [63:0] acc_rnd;
  logic signed [63:0] err_diff;
  logic signed [42:0] delta;
  logic signed [42:0] w_sum;
  logic signed [31:0] w_new;

  // The newest sample sits just below the write position; older ones go downward.
  assign slot_start = (wpos == '0) ? LAST : wpos - AW'(1);
  assign slot_dec   = (slot == '0) ? LAST : slot - AW'(1);
  assign wpos_inc   = (wpos == LAST) ? '0 : wpos + AW'(1);

  assign abs_x   = x_q[15] ? 16'(-x_q) : x_q;
  assign abs_err = err[15] ? 16'(-err) : err;

  // Rounding half up and a 28-bit arithmetic shift is floor((acc + 2^27) / 2^28).
  assign acc_rnd  = acc + 64'sd134217728;
  assign err_diff = {{48{ref_r[15]}}, ref_r} - {{28{est_full[35]}}, est_full};

  assign delta = neg ? -43'(div_mag) : 43'(div_mag);
  assign w_sum = {{11{w_q[31]}}, w_q} + delta;
  assign w_new = nlms_pkg::sat32({{21{w_sum[42]}}, w_sum});

  // Numerator mu * |e| * |x| * 2^13 plus half the divisor for rounding to nearest.
  assign dividend = nlms_pkg::NUM_W'({prod[47:0], 13'd0})
                  + nlms_pkg::NUM_W'(dsum >> 1);

  assign item_ready = (state == S_IDLE);
  assign cfg_ready  = 1'b1;

  // Memory ports.
  assign x_we    = (state == S_CLEAR) || (state == S_STORE);
  assign x_waddr = (state == S_CLEAR) ? k : wpos;
  assign x_wdata = (state == S_CLEAR) ? 16'sd0 : sample_r;
  assign x_addr  = (state == S_NORM) ? k : slot;
  assign w_we    = (state == S_CLEAR) || (state == S_WB);
  assign w_wdata = (state == S_CLEAR) ? 32'sd0 : w_new;

  always_ff @(posedge clk) begin
    if (x_we) begin
      x_mem[x_waddr] <= x_wdata;
    end
    x_q <= x_mem[x_addr];
  end

  always_ff @(posedge clk) begin
    if (w_we) begin
      w_mem[k] <= w_wdata;
    end
    w_q <= w_mem[k];
  end

  // Operand selection for the shared multiplier.
  always_comb begin
    mul_a    = '0;
    mul_b    = '0;
    acc_init = '0;
    case (state)
      S_FILT: begin
        mul_a = {w_q[31], w_q};
        mul_b = {x_q[15], x_q};
      end
      S_NORM: begin
        mul_a    = 33'(x_q);
        mul_b    = {x_q[15], x_q};
        acc_init = {32'd0, regularization};
      end
      S_COEF: begin
        mul_a = {17'd0, step_size};
        mul_b = {1'b0, abs_err};
      end
      S_ADAPT: begin
        mul_a = {1'b0, coef};
        mul_b = {1'b0, abs_x};
      end
      default: begin
        mul_a = '0;
      end
    endcase
  end

  always_comb begin
    mac_ctl.mul_en = ((state == S_FILT || state == S_NORM || state == S_ADAPT) && ph == 2'd1)
                   || (state == S_COEF && ph == 2'd0);
    if ((state == S_FILT || state == S_NORM) && ph == 2'd3) begin
      mac_ctl.acc_op = nlms_pkg::ACC_INIT;
    end else if ((state == S_FILT || state == S_NORM) && ph == 2'd2) begin
      mac_ctl.acc_op = nlms_pkg::ACC_ADD;
    end else begin
      mac_ctl.acc_op = nlms_pkg::ACC_HOLD;
    end
  end

  assign div_start = (state == S_ADAPT) && (ph == 2'd2);

  nlms_mac u_mac (
    .clk      (clk),
    .ctl      (mac_ctl),
    .a        (mul_a),
    .b        (mul_b),
    .acc_init (acc_init),
    .prod     (prod),
    .acc      (acc)
  );

  nlms_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (dividend),
    .divisor  (dsum),
    .done     (div_done),
    .mag      (div_mag)
  );

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      step_size        <= nlms_pkg::STEP_RESET;
      regularization   <= nlms_pkg::REG_RESET;
      error_input_mode <= 1'b0;
    end else if (cfg_valid) begin
      case (cfg_index)
        nlms_pkg::CFG_STEP_SIZE:  step_size        <= cfg_data[15:0];
        nlms_pkg::CFG_REGULARIZE: regularization   <= cfg_data;
        nlms_pkg::CFG_ERROR_MODE: error_input_mode <= cfg_data[0];
        default:                  step_size        <= step_size;
      endcase
    end
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_CLEAR;
      ph           <= 2'd0;
      k            <= '0;
      slot         <= '0;
      wpos         <= '0;
      mode         <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      // In the done state the result register is loaded below instead.
      if (result_valid && result_ready && state != S_DONE) begin
        result_valid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          if (k == LAST) begin
            k     <= '0;
            state <= S_IDLE;
          end else begin
            k <= k + AW'(1);
          end
        end
        S_IDLE: begin
          if (item_valid) begin
            sample_r <= item.sample;
            ref_r    <= item.reference;
            mode     <= error_input_mode;
            if (error_input_mode) begin
              err   <= item.reference;
              ph    <= 2'd3;
              state <= S_NORM;
            end else begin
              state <= S_STORE;
            end
          end
        end
        S_STORE: begin
          wpos  <= wpos_inc;
          ph    <= 2'd3;
          state <= S_FILT;
        end
        S_FILT, S_NORM: begin
          case (ph)
            2'd3: begin
              k    <= '0;
              slot <= slot_start;
              ph   <= 2'd0;
            end
            2'd0: ph <= 2'd1;
            2'd1: ph <= 2'd2;
            default: begin
              k    <= k + AW'(1);
              slot <= slot_dec;
              ph   <= 2'd0;
              if (k == LAST) begin
                state <= (state == S_FILT) ? S_ROUND : S_NCHK;
              end
            end
          endcase
        end
        S_ROUND: begin
          est_full <= acc_rnd[63:28];
          state    <= mode ? S_DONE : S_ERR;
        end
        S_ERR: begin
          err   <= nlms_pkg::sat16(err_diff);
          ph    <= 2'd3;
          state <= S_NORM;
        end
        S_NCHK: begin
          dsum <= acc[nlms_pkg::DIV_W-1:0];
          ph   <= 2'd0;
          if (acc == 64'sd0) begin
            state <= mode ? S_STORE : S_DONE;
          end else begin
            state <= S_COEF;
          end
        end
        S_COEF: begin
          if (ph == 2'd0) begin
            ph <= 2'd1;
          end else begin
            coef  <= prod[31:0];
            k     <= '0;
            slot  <= slot_start;
            ph    <= 2'd0;
            state <= S_ADAPT;
          end
        end
        S_ADAPT: begin
          case (ph)
            2'd0: ph <= 2'd1;
            2'd1: begin
              neg <= err[15] ^ x_q[15];
              ph  <= 2'd2;
            end
            default: begin
              ph    <= 2'd0;
              state <= S_DIV;
            end
          endcase
        end
        S_DIV: begin
          if (div_done) begin
            state <= S_WB;
          end
        end
        S_WB: begin
          k    <= k + AW'(1);
          slot <= slot_dec;
          if (k == LAST) begin
            state <= mode ? S_STORE : S_DONE;
          end else begin
            state <= S_ADAPT;
          end
        end
        S_DONE: begin
          if (!result_valid || result_ready) begin
            result.estimate    <= nlms_pkg::sat16({{28{est_full[35]}}, est_full});
            result.error_value <= err;
            result_valid       <= 1'b1;
            state              <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // The divider only finishes while the sequencer waits for it.
  assert property (@(posedge clk) disable iff (rst) div_done |-> state == S_DIV)
    else $error("divider finished outside of the wait state");

  // The write position always stays inside the delay line.
  assert property (@(posedge clk) disable iff (rst) wpos <= LAST)
    else $error("write position out of range");

  // An accepted item always starts work at once.
  assert property (@(posedge clk) disable iff (rst)
    item_valid && item_ready |=> state == S_STORE || state == S_NORM)
    else $error("accepted item did not start processing");

  // A result is only loaded when the output register is free.
  assert property (@(posedge clk) disable iff (rst)
    state == S_DONE && result_valid && !result_ready |=> state == S_DONE)
    else $error("result overwritten while the receiver stalls");

endmodule
